>>> rtl/layer_alpha_compositor_unit_assert.svh
// ----------------------------------------------------------------------------
// Layer alpha compositor assertion macros
// Concurrent assertion wrappers. They are empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LAYER_ALPHA_COMPOSITOR_UNIT_ASSERT_SVH
`define LAYER_ALPHA_COMPOSITOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define LAC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("layer alpha compositor assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("layer alpha compositor assertion failed");

`else

`define LAC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LAC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/lac_pkg.sv
// ----------------------------------------------------------------------------
// Layer alpha compositor package
// Widths, register indexes, reset values and state codes of the compositor.
// ----------------------------------------------------------------------------
package lac_pkg;

	localparam int unsigned LAYERS_DEFAULT = 8;

	localparam int unsigned PIXEL_W   = 32;
	localparam int unsigned INDEX_W   = 3;
	localparam int unsigned COUNT_W   = 4;
	localparam int unsigned MASK_W    = 8;
	localparam int unsigned OPA_W     = 7;
	localparam int unsigned OPAS_W    = 56;
	localparam int unsigned APB_DATA_W = 64;
	localparam int unsigned APB_ADDR_W = 6;

	localparam logic [PIXEL_W-1:0] BACKGROUND_RST = '0;
	localparam logic [COUNT_W-1:0] LAYER_COUNT_RST = 4'd1;
	localparam logic [MASK_W-1:0]  VISIBLE_RST = 8'd1;
	localparam logic [OPA_W-1:0]   OPA_FULL = 7'd100;
	localparam logic [OPAS_W-1:0]  OPACITIES_RST = {8{OPA_FULL}};

	// Rounded percent scaling: (alpha * pct + 50) / 100, the division done as
	// a multiply by 2^19 / 100 rounded up and a shift by 19.
	localparam logic [5:0]  OPA_ROUND = 6'd50;
	localparam logic [13:0] RECIP_100 = 14'd5243;
	localparam int unsigned RECIP_SHIFT = 19;

	localparam logic [7:0] ALPHA_ZERO = 8'h00;
	localparam logic [7:0] ALPHA_FULL = 8'hFF;
	localparam logic [7:0] MIX_ROUND  = 8'd127;

	typedef enum logic [2:0] {
		REG_BACKGROUND   = 3'd0,
		REG_LAYER_COUNT  = 3'd1,
		REG_VISIBLE_MASK = 3'd2,
		REG_SOLO_ENABLE  = 3'd3,
		REG_SOLO_LAYER   = 3'd4,
		REG_OPACITIES    = 3'd5
	} lac_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OPA_MUL,
		ST_OPA_DIV,
		ST_BLEND,
		ST_DONE
	} lac_state_t;

	typedef enum logic [1:0] {
		CH_RED   = 2'd0,
		CH_GREEN = 2'd1,
		CH_BLUE  = 2'd2,
		CH_ALPHA = 2'd3
	} lac_chan_t;

endpackage

>>> rtl/lac_if.sv
// ----------------------------------------------------------------------------
// Layer alpha compositor channel interfaces
// Valid/ready channels for layer pixels in and composited pixels out.
// ----------------------------------------------------------------------------
interface lac_layer_if;
	import lac_pkg::*;

	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] layer_pixel;
	logic [INDEX_W-1:0] layer_pos;
	logic               last_layer;

	modport source (output valid, output layer_pixel, output layer_pos,
		output last_layer, input ready);
	modport sink (input valid, input layer_pixel, input layer_pos,
		input last_layer, output ready);
endinterface

interface lac_pixel_if;
	import lac_pkg::*;

	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] composite_pixel;

	modport source (output valid, output composite_pixel, input ready);
	modport sink (input valid, input composite_pixel, output ready);
endinterface

>>> rtl/layer_alpha_compositor_unit.sv
// A skipped layer goes from idle straight to done; other layers may first scale
// their alpha by the percent opacity, then may blend the four channels in turn.
// Layers go one at a time through the single shared multiplier that serves the
// opacity scaling and all four channels; a last layer waits longer while the
// previous composite is still held. Reset: asynchronous, active low;
// configuration and sequencer registers return to their defaults and the next
// transaction starts a new pixel from the background colour.
// ----------------------------------------------------------------------------
// Layer alpha compositor
// Source-over blending of a stack of ARGB8888 layer pixels with per-layer
// percent opacity, visibility and solo control.
// ----------------------------------------------------------------------------
`include "layer_alpha_compositor_unit_assert.svh"

module layer_alpha_compositor_unit #(
	parameter int unsigned LAYERS = lac_pkg::LAYERS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	lac_layer_if.sink                       layer_in,
	lac_pixel_if.source                     pixel_out,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lac_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [lac_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [lac_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import lac_pkg::*;

	// Configuration registers
	logic [PIXEL_W-1:0] background_q;
	logic [COUNT_W-1:0] layer_count_q;
	logic [MASK_W-1:0]  visible_mask_q;
	logic               solo_enable_q;
	logic [INDEX_W-1:0] solo_layer_q;
	logic [OPAS_W-1:0]  opacities_q;

	// Sequencer and datapath
	lac_state_t         state_q, state_d;
	lac_chan_t          ch_q;
	logic               in_progress_q;
	logic               last_q;
	logic [PIXEL_W-1:0] comp_q;
	logic [PIXEL_W-1:0] src_q;
	logic [OPA_W-1:0]   pct_q;
	logic [14:0]        t_q;
	logic               out_valid_q;
	logic [PIXEL_W-1:0] out_pixel_q;

	logic               cfg_wr;
	lac_reg_t           reg_sel;
	logic               accept;
	logic               keep_c;
	logic [COUNT_W-1:0] count_c;
	logic [OPA_W-1:0]   pct_c;
	logic [7:0]         in_alpha;
	logic               out_load;

	logic signed [16:0] mul_a;
	logic signed [13:0] mul_b;
	logic signed [30:0] prod;
	logic [7:0]         scaled_alpha;
	logic [7:0]         s_byte, d_byte, sa;
	logic signed [31:0] mix_sum;
	logic [16:0]        mix_v;
	logic [17:0]        div_sum;
	logic [7:0]         div_q;
	logic [7:0]         ch_res;

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = lac_reg_t'(paddr[APB_ADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			background_q   <= BACKGROUND_RST;
			layer_count_q  <= LAYER_COUNT_RST;
			visible_mask_q <= VISIBLE_RST;
			solo_enable_q  <= 1'b0;
			solo_layer_q   <= '0;
			opacities_q    <= OPACITIES_RST;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_BACKGROUND:   background_q   <= pwdata[PIXEL_W-1:0];
				REG_LAYER_COUNT:  layer_count_q  <= pwdata[COUNT_W-1:0];
				REG_VISIBLE_MASK: visible_mask_q <= pwdata[MASK_W-1:0];
				REG_SOLO_ENABLE:  solo_enable_q  <= pwdata[0];
				REG_SOLO_LAYER:   solo_layer_q   <= pwdata[INDEX_W-1:0];
				REG_OPACITIES:    opacities_q    <= pwdata[OPAS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_sel)
			REG_BACKGROUND:   prdata = APB_DATA_W'(background_q);
			REG_LAYER_COUNT:  prdata = APB_DATA_W'(layer_count_q);
			REG_VISIBLE_MASK: prdata = APB_DATA_W'(visible_mask_q);
			REG_SOLO_ENABLE:  prdata = APB_DATA_W'(solo_enable_q);
			REG_SOLO_LAYER:   prdata = APB_DATA_W'(solo_layer_q);
			REG_OPACITIES:    prdata = APB_DATA_W'(opacities_q);
			default:          prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Layer selection at acceptance
	// ------------------------------------------------------------------
	assign layer_in.ready = (state_q == ST_IDLE);
	assign accept         = layer_in.valid && layer_in.ready;
	assign in_alpha       = layer_in.layer_pixel[31:24];

	assign count_c = (layer_count_q > COUNT_W'(LAYERS)) ? COUNT_W'(LAYERS) : layer_count_q;
	assign pct_c   = opacities_q[OPA_W*int'(layer_in.layer_pos) +: OPA_W];

	always_comb begin
		keep_c = ({1'b0, layer_in.layer_pos} < count_c);
		if (solo_enable_q) begin
			if (layer_in.layer_pos != solo_layer_q)
				keep_c = 1'b0;
		end else if (!visible_mask_q[layer_in.layer_pos]) begin
			keep_c = 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Shared multiplier and rounded divide by 255
	// ------------------------------------------------------------------
	assign sa = src_q[31:24];

	always_comb begin
		case (ch_q)
			CH_RED:   begin s_byte = src_q[23:16]; d_byte = comp_q[23:16]; end
			CH_GREEN: begin s_byte = src_q[15:8];  d_byte = comp_q[15:8];  end
			CH_BLUE:  begin s_byte = src_q[7:0];   d_byte = comp_q[7:0];   end
			default:  begin s_byte = src_q[31:24]; d_byte = comp_q[31:24]; end
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_OPA_MUL: begin
				mul_a = 17'($unsigned(src_q[31:24]));
				mul_b = 14'($unsigned(pct_q));
			end
			ST_OPA_DIV: begin
				mul_a = 17'($unsigned(t_q));
				mul_b = RECIP_100;
			end
			ST_BLEND: begin
				if (ch_q == CH_ALPHA) begin
					mul_a = 17'($unsigned(d_byte));
					mul_b = 14'($unsigned(ALPHA_FULL - sa));
				end else begin
					// Colour channels use d*255 + (s - d)*a, one product per channel.
					mul_a = 17'($signed({1'b0, s_byte}) - $signed({1'b0, d_byte}));
					mul_b = 14'($unsigned(sa));
				end
			end
			default: ;
		endcase
	end

	assign prod         = 31'(mul_a) * 31'(mul_b);
	assign scaled_alpha = prod[RECIP_SHIFT+7:RECIP_SHIFT];

	always_comb begin
		if (ch_q == CH_ALPHA)
			mix_sum = 32'(prod) + 32'($unsigned(MIX_ROUND));
		else
			mix_sum = 32'(prod) + 32'($unsigned({d_byte, 8'h00}))
				- 32'($unsigned(d_byte)) + 32'($unsigned(MIX_ROUND));
	end

	// The sum stays below 65536, where (v + (v >> 8) + 1) >> 8 equals v / 255.
	assign mix_v   = mix_sum[16:0];
	assign div_sum = 18'(mix_v) + 18'(mix_v[16:8]) + 18'd1;
	assign div_q   = div_sum[15:8];
	assign ch_res  = (ch_q == CH_ALPHA) ? 8'(sa + div_q) : div_q;

	assign out_load = (state_q == ST_DONE) && last_q && (!out_valid_q || pixel_out.ready);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!keep_c || pct_c == '0)
						state_d = ST_DONE;
					else if (pct_c < OPA_FULL)
						state_d = ST_OPA_MUL;
					else if (in_alpha == ALPHA_ZERO || in_alpha == ALPHA_FULL)
						state_d = ST_DONE;
					else
						state_d = ST_BLEND;
				end
			end
			ST_OPA_MUL: state_d = ST_OPA_DIV;
			ST_OPA_DIV: begin
				if (scaled_alpha == ALPHA_ZERO || scaled_alpha == ALPHA_FULL)
					state_d = ST_DONE;
				else
					state_d = ST_BLEND;
			end
			ST_BLEND: begin
				if (ch_q == CH_ALPHA)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!last_q || out_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					src_q  <= layer_in.layer_pixel;
					pct_q  <= pct_c;
					last_q <= layer_in.last_layer;
					ch_q   <= CH_RED;
					// A fully opaque source at full opacity replaces the composite.
					if (keep_c && pct_c >= OPA_FULL && in_alpha == ALPHA_FULL)
						comp_q <= layer_in.layer_pixel;
					else if (!in_progress_q)
						comp_q <= background_q;
				end
			end
			ST_OPA_MUL: begin
				t_q <= 15'(prod) + 15'(OPA_ROUND);
			end
			ST_OPA_DIV: begin
				src_q[31:24] <= scaled_alpha;
				if (scaled_alpha == ALPHA_FULL)
					comp_q <= {scaled_alpha, src_q[23:0]};
			end
			ST_BLEND: begin
				case (ch_q)
					CH_RED:   comp_q[23:16] <= ch_res;
					CH_GREEN: comp_q[15:8]  <= ch_res;
					CH_BLUE:  comp_q[7:0]   <= ch_res;
					default:  comp_q[31:24] <= ch_res;
				endcase
				ch_q <= lac_chan_t'(ch_q + 2'd1);
			end
			default: ;
		endcase
		if (out_load)
			out_pixel_q <= comp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_progress_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (state_q == ST_DONE && !last_q)
				in_progress_q <= 1'b1;
			else if (out_load)
				in_progress_q <= 1'b0;

			if (out_load)
				out_valid_q <= 1'b1;
			else if (pixel_out.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign pixel_out.valid           = out_valid_q;
	assign pixel_out.composite_pixel = out_pixel_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`LAC_ASSERT_NEXT(a_skip_goes_done, clk, arst_n, accept && !keep_c, state_q == ST_DONE)
	`LAC_ASSERT_NEXT(a_alpha_ends_blend, clk, arst_n,
		state_q == ST_BLEND && ch_q == CH_ALPHA, state_q == ST_DONE)
	`LAC_ASSERT_NEXT(a_out_loads_comp, clk, arst_n, out_load,
		out_valid_q && out_pixel_q == $past(comp_q) && !in_progress_q)
	`LAC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, !layer_in.ready)
	`LAC_ASSERT_SAME(a_blend_has_partial_alpha, clk, arst_n, state_q == ST_BLEND,
		sa != ALPHA_ZERO && sa != ALPHA_FULL)

endmodule
